// File: rtl/sfla_pkg.sv
package sfla_pkg;

  localparam int ADDR_BITS = 24;
  localparam int LEN_BITS  = ADDR_BITS + 1;
  localparam int SUM_BITS  = ADDR_BITS + 3;
  localparam int CFG_BITS  = LEN_BITS;

  // Size of the address space, the ceiling for lengths and totals
  localparam logic [LEN_BITS-1:0] SPACE = LEN_BITS'(1) << ADDR_BITS;

  // Operation codes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_MEM  = 2'd1;
  localparam logic [1:0] ST_COMPACT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Fit policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT      = 2'd0;
  localparam logic [1:0] CFG_MEM_SIZE = 2'd1;
  localparam logic [1:0] CFG_RES_SIZE = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [LEN_BITS-1:0] request_size;
    logic [ADDR_BITS-1:0] free_base;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] granted_base;
    logic [LEN_BITS-1:0]  free_bytes;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  length;
  } region_t;

  // Clamp a grown sum to the address space
  function automatic logic [LEN_BITS-1:0] sat_space(input logic [SUM_BITS-1:0] v);
    logic [LEN_BITS-1:0] r;
    r = (v > SUM_BITS'(SPACE)) ? SPACE : v[LEN_BITS-1:0];
    return r;
  endfunction

endpackage

// File: rtl/sfla_region_ram.sv
module sfla_region_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  sfla_pkg::region_t         wdata,
  input  logic [AW-1:0]             raddr,
  output sfla_pkg::region_t         rdata_r
);

  sfla_pkg::region_t mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/segment_free_list_allocator.sv
// Free-region table allocator, one request at a time through one table port.
// Steps: init writes the initial region; allocate scans the entries, then moves
// entries down when a region empties; free scans the entries, then moves entries up
// on insert (writing the new region last) or down when a merge drops an entry.
// A new request is taken only once the last one is done; the table's single port sets the pace.
// Reset (rst_n low, synchronous): empty table, zero free total, registers 0/4096/128.
module segment_free_list_allocator #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sfla_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sfla_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [sfla_pkg::CFG_BITS-1:0]     cfg_wdata
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AB = sfla_pkg::ADDR_BITS;
  localparam int LB = sfla_pkg::LEN_BITS;
  localparam int SB = sfla_pkg::SUM_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_A_RD, S_A_CHK, S_A_UPD, S_D_RD, S_D_WR,
    S_F_RD, S_F_CHK, S_F_ACT, S_I_RD, S_I_WR, S_I_NEW, S_FIN
  } state_t;

  state_t              state_r;
  sfla_pkg::in_t       req_r;
  sfla_pkg::out_t      res_r;
  sfla_pkg::out_t      out_r;
  logic                out_valid_r;
  logic [1:0]          fit_r;
  logic [LB-1:0]       mem_size_r;
  logic [LB-1:0]       res_size_r;
  logic [CW-1:0]       count_r;
  logic [LB-1:0]       total_r;
  logic [CW-1:0]       idx_r;
  logic [IW-1:0]       pick_idx_r;
  sfla_pkg::region_t   pick_r;
  logic                found_r;
  sfla_pkg::region_t   prev_r;
  logic                have_prev_r;
  sfla_pkg::region_t   cur_r;
  logic                have_cur_r;
  logic [CW-1:0]       cur_idx_r;

  // Table port
  logic                we;
  logic [IW-1:0]       waddr;
  sfla_pkg::region_t   wdata;
  logic [IW-1:0]       raddr;
  sfla_pkg::region_t   rdata;

  sfla_region_ram #(.DEPTH(MAX_REGIONS), .AW(IW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata_r(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Init geometry
  logic [LB-1:0] init_mem, init_res, init_len;
  assign init_mem = (mem_size_r > sfla_pkg::SPACE) ? sfla_pkg::SPACE : mem_size_r;
  assign init_res = (res_size_r > init_mem) ? init_mem : res_size_r;
  assign init_len = init_mem - init_res;

  // Fit compare for the entry just read
  logic qual, better;
  assign qual = (rdata.length >= req_r.request_size);
  always_comb begin
    unique case (fit_r)
      sfla_pkg::FIT_FIRST: better = qual;
      sfla_pkg::FIT_BEST:  better = qual && (!found_r || rdata.length < pick_r.length);
      sfla_pkg::FIT_WORST: better = qual && (!found_r || rdata.length > pick_r.length);
      default:             better = 1'b0;
    endcase
  end

  // Neighbor checks for free
  logic below, above;
  assign below = have_prev_r &&
    ((SB'(prev_r.start) + SB'(prev_r.length)) == SB'(req_r.free_base));
  assign above = have_cur_r &&
    ((SB'(req_r.free_base) + SB'(req_r.request_size)) == SB'(cur_r.start));

  logic [LB-1:0] new_total, both_len, below_len, above_len, ins_len;
  assign new_total = sfla_pkg::sat_space(SB'(total_r) + SB'(req_r.request_size));
  assign both_len  = sfla_pkg::sat_space(SB'(prev_r.length) + SB'(req_r.request_size)
                                         + SB'(cur_r.length));
  assign below_len = sfla_pkg::sat_space(SB'(prev_r.length) + SB'(req_r.request_size));
  assign above_len = sfla_pkg::sat_space(SB'(cur_r.length) + SB'(req_r.request_size));
  assign ins_len   = sfla_pkg::sat_space(SB'(req_r.request_size));

  logic [CW-1:0] idx_dec;
  assign idx_dec = idx_r - CW'(1);

  // Table read address and write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx_r[IW-1:0];
    unique case (state_r)
      S_OP: begin
        if (req_r.operation == sfla_pkg::OP_INIT) begin
          we    = (init_len != '0);
          wdata = '{start: init_res[AB-1:0], length: init_len};
        end
      end
      S_A_UPD: begin
        we    = 1'b1;
        waddr = pick_idx_r;
        wdata = '{start: pick_r.start + req_r.request_size[AB-1:0],
                  length: pick_r.length - req_r.request_size};
      end
      S_D_WR: begin
        we    = 1'b1;
        waddr = idx_dec[IW-1:0];
        wdata = rdata;
      end
      S_F_ACT: begin
        if (below) begin
          we    = 1'b1;
          waddr = idx_dec[IW-1:0];
          wdata = '{start: prev_r.start, length: above ? both_len : below_len};
        end else if (above) begin
          we    = 1'b1;
          waddr = idx_r[IW-1:0];
          wdata = '{start: req_r.free_base, length: above_len};
        end else if (count_r != CW'(MAX_REGIONS) && idx_r == count_r) begin
          we    = 1'b1;
          waddr = idx_r[IW-1:0];
          wdata = '{start: req_r.free_base, length: ins_len};
        end
      end
      S_I_RD: raddr = idx_dec[IW-1:0];
      S_I_WR: begin
        we    = 1'b1;
        waddr = idx_r[IW-1:0];
        wdata = rdata;
      end
      S_I_NEW: begin
        we    = 1'b1;
        waddr = idx_r[IW-1:0];
        wdata = '{start: req_r.free_base, length: ins_len};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fit_r       <= sfla_pkg::FIT_FIRST;
      mem_size_r  <= LB'(4096);
      res_size_r  <= LB'(128);
      count_r     <= '0;
      total_r     <= '0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      have_cur_r  <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          sfla_pkg::CFG_FIT:      fit_r      <= cfg_wdata[1:0];
          sfla_pkg::CFG_MEM_SIZE: mem_size_r <= cfg_wdata;
          sfla_pkg::CFG_RES_SIZE: res_size_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Output register: load a finished result, or clear once taken
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_OP;
          end
        end

        S_OP: begin
          idx_r       <= '0;
          found_r     <= 1'b0;
          have_prev_r <= 1'b0;
          have_cur_r  <= 1'b0;
          unique case (req_r.operation)
            sfla_pkg::OP_INIT: begin
              count_r <= (init_len != '0) ? CW'(1) : '0;
              total_r <= init_len;
              res_r   <= '{status: sfla_pkg::ST_DONE, granted_base: '0,
                           free_bytes: init_len};
              state_r <= S_FIN;
            end
            sfla_pkg::OP_ALLOC: begin
              if (total_r < req_r.request_size) begin
                res_r   <= '{status: sfla_pkg::ST_NO_MEM, granted_base: '0,
                             free_bytes: total_r};
                state_r <= S_FIN;
              end else if (count_r == '0) begin
                res_r   <= '{status: sfla_pkg::ST_COMPACT, granted_base: '0,
                             free_bytes: total_r};
                state_r <= S_FIN;
              end else begin
                res_r   <= '{status: sfla_pkg::ST_DONE, granted_base: '0,
                             free_bytes: total_r};
                state_r <= S_A_RD;
              end
            end
            sfla_pkg::OP_FREE: begin
              res_r <= '{status: sfla_pkg::ST_DONE, granted_base: '0, free_bytes: total_r};
              if (req_r.request_size == '0) begin
                state_r <= S_FIN;
              end else begin
                state_r <= (count_r == '0) ? S_F_ACT : S_F_RD;
              end
            end
            default: begin
              res_r   <= '{status: sfla_pkg::ST_DONE, granted_base: '0, free_bytes: total_r};
              state_r <= S_FIN;
            end
          endcase
        end

        // Allocate: scan for a fitting region
        S_A_RD: state_r <= S_A_CHK;
        S_A_CHK: begin
          if (better) begin
            found_r    <= 1'b1;
            pick_idx_r <= idx_r[IW-1:0];
            pick_r     <= rdata;
          end
          if (better && fit_r == sfla_pkg::FIT_FIRST) begin
            state_r <= S_A_UPD;
          end else if (idx_r + CW'(1) == count_r) begin
            if (found_r || better) begin
              state_r <= S_A_UPD;
            end else begin
              res_r.status <= sfla_pkg::ST_COMPACT;
              state_r      <= S_FIN;
            end
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_A_RD;
          end
        end
        S_A_UPD: begin
          total_r            <= total_r - req_r.request_size;
          res_r.free_bytes   <= total_r - req_r.request_size;
          res_r.granted_base <= pick_r.start;
          if (pick_r.length == req_r.request_size) begin
            count_r <= count_r - CW'(1);
          end
          if (pick_r.length == req_r.request_size &&
              CW'(pick_idx_r) < count_r - CW'(1)) begin
            idx_r   <= CW'(pick_idx_r) + CW'(1);
            state_r <= S_D_RD;
          end else begin
            state_r <= S_FIN;
          end
        end

        // Close the gap left by a dropped entry
        S_D_RD: state_r <= S_D_WR;
        S_D_WR: begin
          if (idx_r == count_r) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_D_RD;
          end
        end

        // Free: find the first region above the base
        S_F_RD: state_r <= S_F_CHK;
        S_F_CHK: begin
          if (rdata.start <= req_r.free_base) begin
            prev_r      <= rdata;
            have_prev_r <= 1'b1;
            idx_r       <= idx_r + CW'(1);
            state_r     <= (idx_r + CW'(1) == count_r) ? S_F_ACT : S_F_RD;
          end else begin
            cur_r      <= rdata;
            have_cur_r <= 1'b1;
            state_r    <= S_F_ACT;
          end
        end
        S_F_ACT: begin
          if (!below && !above && count_r == CW'(MAX_REGIONS)) begin
            res_r.status <= sfla_pkg::ST_FULL;
            state_r      <= S_FIN;
          end else begin
            total_r          <= new_total;
            res_r.free_bytes <= new_total;
            if (below && above) begin
              count_r <= count_r - CW'(1);
              if (idx_r < count_r - CW'(1)) begin
                idx_r   <= idx_r + CW'(1);
                state_r <= S_D_RD;
              end else begin
                state_r <= S_FIN;
              end
            end else if (!below && !above) begin
              if (idx_r == count_r) begin
                count_r <= count_r + CW'(1);
                state_r <= S_FIN;
              end else begin
                idx_r   <= count_r;
                state_r <= S_I_RD;
              end
            end else begin
              state_r <= S_FIN;
            end
          end
        end

        // Open a slot by moving entries up
        S_I_RD: state_r <= S_I_WR;
        S_I_WR: begin
          idx_r   <= idx_dec;
          state_r <= (idx_dec == cur_idx_r) ? S_I_NEW : S_I_RD;
        end
        S_I_NEW: begin
          count_r <= count_r + CW'(1);
          state_r <= S_FIN;
        end

        // Wait for the output register to take the result
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Insert point, captured when the free scan stops
  always_ff @(posedge clk) begin
    if (state_r == S_F_ACT) cur_idx_r <= idx_r;
  end

endmodule
